[design/pipw_pkg.sv]
// Shared constants, codes and types of the point-in-polygon winding block.
package pipw_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_loc;

    localparam t_mode MODE_CLEAR  = 2'd0;
    localparam t_mode MODE_APPEND = 2'd1;
    localparam t_mode MODE_QUERY  = 2'd2;

    localparam t_loc LOC_INSIDE   = 2'd0;
    localparam t_loc LOC_BOUNDARY = 2'd1;
    localparam t_loc LOC_OUTSIDE  = 2'd2;

    // Verdict of the edge unit for one edge of the polygon.
    typedef struct packed {
        logic valid;
        logic last;
        logic on_bnd;
        logic up;
        logic down;
    } t_edge_res;

endpackage

[design/pipw_if.sv]
// Valid/ready channel interfaces for the point items and the result items.
interface pipw_in_if #(
    parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    pipw_pkg::t_mode              mode;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, mode, coord_x, coord_y, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, output ready);
endinterface

interface pipw_out_if;
    logic           valid;
    logic           ready;
    pipw_pkg::t_loc location;
    logic           overflow;

    modport source (output valid, location, overflow, input ready);
    modport sink   (input valid, location, overflow, output ready);
endinterface

[design/pipw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module pipw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/pipw_edge.sv]
// Three-stage edge unit: crossing product, boundary test and winding step of one edge.
module pipw_edge #(
    parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_last,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output pipw_pkg::t_edge_res          o_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    // Stage 1: endpoints relative to the query point, plus coordinate compares.
    logic signed [DW-1:0] n_dax, n_day, n_dbx, n_dby;
    logic                 n_bbox, n_a_le, n_b_gt;
    logic                 r1_vld, r1_last, r1_bbox, r1_a_le, r1_b_gt;
    logic signed [DW-1:0] r1_dax, r1_day, r1_dbx, r1_dby;

    // Stage 2: the two partial products of the cross product.
    logic                 r2_vld, r2_last, r2_bbox, r2_a_le, r2_b_gt;
    logic signed [PW-1:0] r2_p1, r2_p2;

    // Stage 3: cross product sign and the per-edge verdict.
    logic signed [XW-1:0] n_cross;
    logic                 n_zero, n_pos, n_neg;

    assign n_dax = {i_ax[COORD_BITS-1], i_ax} - {i_qx[COORD_BITS-1], i_qx};
    assign n_day = {i_ay[COORD_BITS-1], i_ay} - {i_qy[COORD_BITS-1], i_qy};
    assign n_dbx = {i_bx[COORD_BITS-1], i_bx} - {i_qx[COORD_BITS-1], i_qx};
    assign n_dby = {i_by[COORD_BITS-1], i_by} - {i_qy[COORD_BITS-1], i_qy};

    // A point collinear with the edge and inside its bounding box lies on it;
    // for a zero-length edge this reduces to equality with the vertex.
    assign n_bbox = ((i_ax <= i_qx && i_qx <= i_bx) || (i_bx <= i_qx && i_qx <= i_ax)) &&
                    ((i_ay <= i_qy && i_qy <= i_by) || (i_by <= i_qy && i_qy <= i_ay));
    assign n_a_le = (i_ay <= i_qy);
    assign n_b_gt = (i_by > i_qy);

    assign n_cross = {r2_p1[PW-1], r2_p1} - {r2_p2[PW-1], r2_p2};
    assign n_zero  = (n_cross == '0);
    assign n_neg   = n_cross[XW-1];
    assign n_pos   = !n_neg && !n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld       <= 1'b0;
            r2_vld       <= 1'b0;
            o_res.valid  <= 1'b0;
        end else begin
            r1_vld       <= i_valid;
            r2_vld       <= r1_vld;
            o_res.valid  <= r2_vld;
        end

        r1_last <= i_last;
        r1_bbox <= n_bbox;
        r1_a_le <= n_a_le;
        r1_b_gt <= n_b_gt;
        r1_dax  <= n_dax;
        r1_day  <= n_day;
        r1_dbx  <= n_dbx;
        r1_dby  <= n_dby;

        r2_last <= r1_last;
        r2_bbox <= r1_bbox;
        r2_a_le <= r1_a_le;
        r2_b_gt <= r1_b_gt;
        r2_p1   <= r1_dax * r1_dby;
        r2_p2   <= r1_day * r1_dbx;

        o_res.last   <= r2_last;
        o_res.on_bnd <= r2_bbox && n_zero;
        o_res.up     <= r2_a_le && r2_b_gt && n_pos;
        o_res.down   <= !r2_a_le && !r2_b_gt && n_neg;
    end

endmodule

[design/point_in_polygon_winding_core.sv]
// Top level of the point-in-polygon classifier using the winding-number rule.
//
// Items arrive on i_pt (mode, coord_x, coord_y). A clear item empties the polygon
// and the overflow flag; an append item stores one vertex, or sets the sticky
// overflow flag when MAX_VERTICES vertices are already held. Neither makes a
// result. A query item makes exactly one result item on o_res (location, overflow).
// Vertices live in one RAM with a registered read. A query reads the n stored vertices
// one per cycle, forms each edge, the closing one included, from the previous and the
// current vertex, and pushes it through a three-stage edge unit that tests for boundary
// contact and adds the winding step. A query walks its edges, drains the edge unit and
// then registers its result, and the next item is taken only after that; the single
// RAM read port sets the pace of one edge per cycle. An empty polygon skips the walk
// and goes straight to the result state.
// i_pt.ready is high only while no query is in progress. The result sits in an output
// register, so clear and append items are still taken while the receiver stalls; a
// following query can walk its edges but holds its result until the register frees.
// Reset empties the polygon, clears the overflow flag and the output register. The RAM
// is not cleared: entries at or beyond the vertex count are never used.
module point_in_polygon_winding_core #(
    parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pipw_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pipw_in_if.sink           i_pt,
    pipw_out_if.source        o_res
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int WNW = CW + 1;
    localparam int VW  = 2 * COORD_BITS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic          r_out_valid;
    pipw_pkg::t_loc r_out_loc;
    logic          r_out_ovf;

    // Query context.
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic [CW-1:0]                r_n;
    logic [CW-1:0]                r_issue;
    logic                         r_bnd;
    logic signed [WNW-1:0]        r_wn;

    // Read-return stage: tag of the slot whose data arrives from the RAM now.
    logic                         r_t_vld, r_t_first, r_t_close;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;

    logic                         accept;
    logic                         ram_we;
    logic [VW-1:0]                ram_rdata;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic                         edge_vld;
    pipw_pkg::t_edge_res          edge_res;
    pipw_pkg::t_loc               n_loc;

    assign i_pt.ready     = (r_state == S_IDLE);
    assign accept         = i_pt.valid && i_pt.ready;
    assign ram_we         = accept && (i_pt.mode == pipw_pkg::MODE_APPEND) &&
                            (r_count < CW'(MAX_VERTICES));

    assign o_res.valid    = r_out_valid;
    assign o_res.location = r_out_loc;
    assign o_res.overflow = r_out_ovf;

    // The closing slot ignores the RAM data; it reuses the first vertex instead.
    assign cur_x    = r_t_close ? r_first_x : ram_rdata[COORD_BITS-1:0];
    assign cur_y    = r_t_close ? r_first_y : ram_rdata[VW-1:COORD_BITS];
    assign edge_vld = r_t_vld && !r_t_first;

    always_comb begin
        if (r_bnd) begin
            n_loc = pipw_pkg::LOC_BOUNDARY;
        end else if (r_wn != '0) begin
            n_loc = pipw_pkg::LOC_INSIDE;
        end else begin
            n_loc = pipw_pkg::LOC_OUTSIDE;
        end
    end

    pipw_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_pt.coord_y, i_pt.coord_x}),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    pipw_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (edge_vld),
        .i_last  (r_t_close),
        .i_ax    (r_prev_x),
        .i_ay    (r_prev_y),
        .i_bx    (cur_x),
        .i_by    (cur_y),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_res   (edge_res)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_t_vld     <= 1'b0;
        end else begin
            r_t_vld <= (r_state == S_WALK);
            // A finished query loads the output register when it is free or
            // being emptied in this cycle; otherwise a taken result empties it.
            if (r_state == S_RESULT && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_pt.mode)
                            pipw_pkg::MODE_CLEAR: begin
                                r_count   <= '0;
                                r_dropped <= 1'b0;
                            end
                            pipw_pkg::MODE_APPEND: begin
                                if (ram_we) begin
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                            pipw_pkg::MODE_QUERY: begin
                                r_state <= (r_count == '0) ? S_RESULT : S_WALK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_issue == r_n) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (edge_res.valid && edge_res.last) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Query context, walk counter, accumulators and result payload.
    always_ff @(posedge i_clk) begin
        r_t_first <= (r_issue == '0);
        r_t_close <= (r_issue == r_n);

        if (accept && i_pt.mode == pipw_pkg::MODE_QUERY) begin
            r_qx    <= i_pt.coord_x;
            r_qy    <= i_pt.coord_y;
            r_n     <= r_count;
            r_issue <= '0;
            r_bnd   <= 1'b0;
            r_wn    <= '0;
        end else begin
            if (r_state == S_WALK) begin
                r_issue <= r_issue + CW'(1);
            end
            if (edge_res.valid) begin
                r_bnd <= r_bnd || edge_res.on_bnd;
                if (edge_res.up) begin
                    r_wn <= r_wn + WNW'(1);
                end else if (edge_res.down) begin
                    r_wn <= r_wn - WNW'(1);
                end
            end
        end

        if (r_t_vld) begin
            if (r_t_first) begin
                r_first_x <= cur_x;
                r_first_y <= cur_y;
            end
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end

        if (r_state == S_RESULT && (!r_out_valid || o_res.ready)) begin
            r_out_loc <= n_loc;
            r_out_ovf <= r_dropped;
        end
    end

endmodule
